/* rtl/b64d_pkg.sv */
`default_nettype none

package b64d_pkg;

    // Reset value of the output capacity register
    localparam logic [15:0] CAP_RESET = 16'd2048;

    // Output queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    // Sextet offsets of the alphabet ranges
    localparam logic [5:0] SX_LOWER = 6'd26;
    localparam logic [5:0] SX_DIGIT = 6'd52;
    localparam logic [5:0] SX_PLUS  = 6'd62;
    localparam logic [5:0] SX_SLASH = 6'd63;

    typedef struct packed {
        logic [7:0] in_char;
        logic       char_present;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_data;
        logic        status;
        logic [15:0] byte_count;
        logic        last;
    } out_item_t;

    // Results of one item handed to the output queue, first in order first
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } push_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } sextet_t;

    // Map a character to its 6-bit value; hit is low outside the alphabet
    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t r;
        logic [7:0] d;
        r.hit   = 1'b0;
        r.value = 6'd0;
        d       = 8'd0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
        begin
            d       = ch - CH_UPPER_A;
            r.hit   = 1'b1;
            r.value = d[5:0];
        end
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
        begin
            d       = ch - CH_LOWER_A;
            r.hit   = 1'b1;
            r.value = d[5:0] + SX_LOWER;
        end
        else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
        begin
            d       = ch - CH_DIGIT_0;
            r.hit   = 1'b1;
            r.value = d[5:0] + SX_DIGIT;
        end
        else if (ch == CH_PLUS)
        begin
            r.hit   = 1'b1;
            r.value = SX_PLUS;
        end
        else if (ch == CH_SLASH)
        begin
            r.hit   = 1'b1;
            r.value = SX_SLASH;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/b64d_core.sv */
`default_nettype none

module b64d_core
    import b64d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        room,
    output push_t            push
);

    logic        item_valid_reg, item_valid_next;
    in_item_t    item_reg;
    logic [15:0] cap_reg;
    logic [11:0] acc_reg, acc_next;
    logic [3:0]  pend_reg, pend_next;
    logic        pad_reg, pad_next;
    logic        err_reg, err_next;
    logic [15:0] cnt_reg, cnt_next;

    logic        advance;
    logic        load;
    sextet_t     sx;
    logic [11:0] acc_shift;
    logic [3:0]  pend_sum;
    logic [3:0]  pend_left;
    logic [11:0] acc_aligned;
    logic        emit;
    out_item_t   data_res;
    out_item_t   stat_res;

    // Input register: refill when empty or when the held item advances
    assign advance  = item_valid_reg && room;
    assign in_stall = item_valid_reg && !room;
    assign load     = !item_valid_reg || room;
    assign item_valid_next = load ? in_valid : item_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // Hold payload until the item advances
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= in_data;
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Decode one character and build its results
    assign sx          = sextet_of(item_reg.in_char);
    assign acc_shift   = {acc_reg[5:0], sx.value};
    assign pend_sum    = pend_reg + 4'd6;
    assign pend_left   = pend_sum - 4'd8;
    assign acc_aligned = acc_shift >> pend_left;

    always_comb
    begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        cnt_next  = cnt_reg;
        emit      = 1'b0;

        if (item_reg.char_present && !err_reg)
        begin
            if (item_reg.in_char == CH_PAD)
            begin
                pad_next = 1'b1;
            end
            else if (sx.hit)
            begin
                if (pad_reg)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    acc_next  = acc_shift;
                    pend_next = pend_sum;
                    if (pend_sum >= 4'd8)
                    begin
                        pend_next = pend_left;
                        if (cnt_reg >= cap_reg)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 16'd1;
                            emit     = 1'b1;
                        end
                    end
                end
            end
        end

        data_res.data_byte  = acc_aligned[7:0];
        data_res.is_data    = 1'b1;
        data_res.status     = 1'b0;
        data_res.byte_count = cnt_next;
        data_res.last       = 1'b0;

        stat_res.data_byte  = 8'd0;
        stat_res.is_data    = 1'b0;
        stat_res.status     = err_next;
        stat_res.byte_count = cnt_next;
        stat_res.last       = 1'b1;

        // Order the results: the data byte goes ahead of the status
        push.first  = emit ? data_res : stat_res;
        push.second = stat_res;
        if (!advance)
        begin
            push.count = 2'd0;
        end
        else
        begin
            push.count = {1'b0, emit} + {1'b0, item_reg.end_of_input};
        end
    end

    // Decoder state: update on advance, clear at end of block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 12'd0;
            pend_reg <= 4'd0;
            pad_reg  <= 1'b0;
            err_reg  <= 1'b0;
            cnt_reg  <= 16'd0;
        end
        else if (advance)
        begin
            if (item_reg.end_of_input)
            begin
                acc_reg  <= 12'd0;
                pend_reg <= 4'd0;
                pad_reg  <= 1'b0;
                err_reg  <= 1'b0;
                cnt_reg  <= 16'd0;
            end
            else
            begin
                acc_reg  <= acc_next;
                pend_reg <= pend_next;
                pad_reg  <= pad_next;
                err_reg  <= err_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/b64d_out_queue.sv */
`default_nettype none

module b64d_out_queue
    import b64d_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire push_t     push,
    output logic           room,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);

    out_item_t        mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic [QAW-1:0]   wr_ptr_second;
    logic             pop;

    // Room for a full item's worth of results
    assign room      = count_reg <= QCW'(QDEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    assign wr_ptr_second = wr_ptr_reg + QAW'(1);
    assign wr_ptr_next   = wr_ptr_reg + QAW'(push.count);
    assign rd_ptr_next   = rd_ptr_reg + QAW'(pop);
    assign count_next    = count_reg + QCW'(push.count) - QCW'(pop);

    // Write up to two results per cycle
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_second] <= push.second;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/base64_stream_decoder.sv */
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall    in_data   (in_item_t)
// out       output     out_valid/out_stall  out_data  (out_item_t)
// cfg       input      cfg_wr_en            cfg_wr_data (output capacity)
//
// One character per cycle while in_stall is low: an item waits in the input
// register, and its results enter a four-entry output queue on the same edge
// it advances. The output port drains one result per cycle while out_stall
// is low, so an item with a byte and an end marker yields two results.
// The input stalls only while the output queue has fewer than two free slots.
// Reset clears the decoder state and the queue, and loads capacity 2048.
`default_nettype none

module base64_stream_decoder
    import b64d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    push_t push;
    logic  room;

    // Decode stage
    b64d_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .room        (room),
        .push        (push)
    );

    // Result queue
    b64d_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    // The end flag marks only the status result
    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> !out_data.is_data)
        else $error("last set on a data result");

    // Every non-data result closes the block
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_data |-> out_data.last)
        else $error("status result without last");

    // Data results never report malformed
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_data |-> !out_data.status)
        else $error("malformed flag on a data result");

    // A status result's byte counter follows the last data byte's count
    a_count_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.is_data |=>
        !(out_valid && !out_data.is_data) || out_data.byte_count == $past(out_data.byte_count))
        else $error("status byte count differs from last data count");
`endif

endmodule

`default_nettype wire
